>>> rtl/core/ssi_pkg.sv
// Package for the segment/sphere intersection block: word types, widths and
// the side-band structs carried through the root and divide pipelines.
// Depends on nothing; every other file of the block uses it.
package ssi_pkg;

  localparam int COORD_W = 32;
  localparam int DW = COORD_W + 1;
  localparam int AW = 2 * COORD_W + 4;
  localparam int CW = 2 * COORD_W + 5;
  localparam int XW = 4 * COORD_W + 10;
  localparam int SW = XW / 2;
  localparam int NW = 2 * COORD_W + 7;
  localparam int TW = AW + DW;
  localparam int NUMW = TW + 2;
  localparam int DENW = AW + 1;
  localparam int QW = COORD_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic signed [COORD_W-1:0] centre_z;
    logic [COORD_W-2:0]        radius;
  } in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } out_t;

  typedef struct packed {
    logic signed [AW-1:0]      a;
    logic signed [AW-1:0]      b;
    logic signed [COORD_W-1:0] p0;
    logic signed [COORD_W-1:0] p1;
    logic signed [COORD_W-1:0] p2;
    logic signed [DW-1:0]      d0;
    logic signed [DW-1:0]      d1;
    logic signed [DW-1:0]      d2;
    logic                      degen;
    logic                      dhit;
    logic                      ok;
  } sq_side_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] p;
    logic                      neg;
    logic                      hit;
    logic                      pos;
  } div_side_t;

endpackage

>>> rtl/core/ssi_sqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Uses ssi_pkg for widths and the side-band struct that travels alongside.
module ssi_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [ssi_pkg::XW-1:0]  x,
  input  ssi_pkg::sq_side_t       side_in,
  output logic                    out_valid,
  output logic [ssi_pkg::SW-1:0]  root,
  output ssi_pkg::sq_side_t       side_out
);

  localparam int XW = ssi_pkg::XW;
  localparam int SW = ssi_pkg::SW;
  localparam int RW = SW + 3;

  logic              v_q    [SW];
  logic [RW-1:0]     rem_q  [SW];
  logic [SW-1:0]     root_q [SW];
  logic [XW-1:0]     x_q    [SW];
  ssi_pkg::sq_side_t side_q [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic              pv;
    logic [RW-1:0]     prem;
    logic [SW-1:0]     proot;
    logic [XW-1:0]     px;
    ssi_pkg::sq_side_t pside;
    logic [RW-1:0]     r2;
    logic [RW-1:0]     trial;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign prem = '0;
      assign proot = '0;
      assign px = x;
      assign pside = side_in;
    end else begin : g_next
      assign pv = v_q[k-1];
      assign prem = rem_q[k-1];
      assign proot = root_q[k-1];
      assign px = x_q[k-1];
      assign pside = side_q[k-1];
    end

    assign r2 = {prem[RW-3:0], px[XW-1:XW-2]};
    assign trial = {1'b0, proot, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[k] <= {px[XW-3:0], 2'b00};
        side_q[k] <= pside;
        if (r2 >= trial) begin
          rem_q[k] <= r2 - trial;
          root_q[k] <= {proot[SW-2:0], 1'b1};
        end else begin
          rem_q[k] <= r2;
          root_q[k] <= {proot[SW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_q[SW-1];
  assign root = root_q[SW-1];
  assign side_out = side_q[SW-1];

endmodule

>>> rtl/core/ssi_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Uses ssi_pkg for widths and the side-band struct of one coordinate lane.
module ssi_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [ssi_pkg::NUMW-1:0] num,
  input  logic [ssi_pkg::DENW-1:0] den,
  input  ssi_pkg::div_side_t       side_in,
  output logic                     out_valid,
  output logic [ssi_pkg::QW-1:0]   quo,
  output ssi_pkg::div_side_t       side_out
);

  localparam int QW = ssi_pkg::QW;
  localparam int DENW = ssi_pkg::DENW;
  localparam int NUMW = ssi_pkg::NUMW;
  localparam int RW = DENW + 1;

  logic               v_q    [QW];
  logic [RW-1:0]      rem_q  [QW];
  logic [QW-1:0]      lo_q   [QW];
  logic [QW-1:0]      q_q    [QW];
  logic [DENW-1:0]    den_q  [QW];
  ssi_pkg::div_side_t side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic               pv;
    logic [RW-1:0]      prem;
    logic [QW-1:0]      plo;
    logic [QW-1:0]      pq;
    logic [DENW-1:0]    pden;
    ssi_pkg::div_side_t pside;
    logic [RW-1:0]      r2;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign prem = num[NUMW-1:QW];
      assign plo = num[QW-1:0];
      assign pq = '0;
      assign pden = den;
      assign pside = side_in;
    end else begin : g_next
      assign pv = v_q[k-1];
      assign prem = rem_q[k-1];
      assign plo = lo_q[k-1];
      assign pq = q_q[k-1];
      assign pden = den_q[k-1];
      assign pside = side_q[k-1];
    end

    assign r2 = {prem[RW-2:0], plo[QW-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lo_q[k] <= {plo[QW-2:0], 1'b0};
        den_q[k] <= pden;
        side_q[k] <= pside;
        if (r2 >= RW'(pden)) begin
          rem_q[k] <= r2 - RW'(pden);
          q_q[k] <= {pq[QW-2:0], 1'b1};
        end else begin
          rem_q[k] <= r2;
          q_q[k] <= {pq[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_q[QW-1];
  assign quo = q_q[QW-1];
  assign side_out = side_q[QW-1];

endmodule

>>> rtl/core/segment_sphere_intersect.sv
// Segment against sphere intersection: hit flag and entry point per word.
// The root and divide pipelines produce one bit per stage. Throughput is
// one word per cycle; a stall at the output freezes every stage together.
// Reset (synchronous, active high) clears all valid bits; data needs none.
// Depends on ssi_pkg, ssi_sqrt and ssi_div.
module segment_sphere_intersect (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ssi_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ssi_pkg::out_t  out_data
);

  localparam int W = ssi_pkg::COORD_W;
  localparam int DW = ssi_pkg::DW;
  localparam int AW = ssi_pkg::AW;
  localparam int CW = ssi_pkg::CW;
  localparam int XW = ssi_pkg::XW;
  localparam int SW = ssi_pkg::SW;
  localparam int NW = ssi_pkg::NW;
  localparam int NUMW = ssi_pkg::NUMW;
  localparam int DENW = ssi_pkg::DENW;
  localparam int QW = ssi_pkg::QW;

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic signed [W-1:0] ia [3];
  logic signed [W-1:0] ib [3];
  logic signed [W-1:0] ic [3];

  always_comb begin
    ia[0] = in_data.start_x;
    ia[1] = in_data.start_y;
    ia[2] = in_data.start_z;
    ib[0] = in_data.end_x;
    ib[1] = in_data.end_y;
    ib[2] = in_data.end_z;
    ic[0] = in_data.centre_x;
    ic[1] = in_data.centre_y;
    ic[2] = in_data.centre_z;
  end

  logic                 v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic signed [W-1:0]  p1 [3];
  logic signed [DW-1:0] d1 [3];
  logic signed [DW-1:0] m1 [3];
  logic [W-2:0]         r1;

  logic signed [W-1:0]    p2 [3];
  logic signed [DW-1:0]   d2 [3];
  logic signed [2*DW-1:0] dd2 [3];
  logic signed [2*DW-1:0] md2 [3];
  logic signed [2*DW-1:0] mm2 [3];
  logic [2*W-3:0]         rr2;

  logic signed [W-1:0]  p3 [3];
  logic signed [DW-1:0] d3 [3];
  logic signed [AW-1:0] a3, b3;
  logic signed [CW-1:0] c3;
  logic signed [W+1:0]  ah3, bh3, ch3;
  logic [W:0]           al3, bl3, cl3;

  logic signed [W-1:0]      p4 [3];
  logic signed [DW-1:0]     d4 [3];
  logic signed [AW-1:0]     a4, b4;
  logic signed [AW-1:0]     bhh4, bhl4, ahch4, ahcl4, alch4;
  logic [2*W+1:0]           bll4, alcl4;
  logic                     degen4, dhit4, early4;

  logic signed [XW-1:0] disc5;
  ssi_pkg::sq_side_t    side5;

  always_comb begin
    ah3 = a3[2*W+2:W+1];
    al3 = a3[W:0];
    bh3 = b3[2*W+2:W+1];
    bl3 = b3[W:0];
    ch3 = c3[2*W+2:W+1];
    cl3 = c3[W:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1[i] <= ia[i];
        d1[i] <= DW'(ib[i]) - DW'(ia[i]);
        m1[i] <= DW'(ia[i]) - DW'(ic[i]);
        p2[i] <= p1[i];
        d2[i] <= d1[i];
        dd2[i] <= d1[i] * d1[i];
        md2[i] <= m1[i] * d1[i];
        mm2[i] <= m1[i] * m1[i];
        p3[i] <= p2[i];
        d3[i] <= d2[i];
        p4[i] <= p3[i];
        d4[i] <= d3[i];
      end
      r1 <= in_data.radius;
      rr2 <= r1 * r1;
      a3 <= AW'(dd2[0]) + AW'(dd2[1]) + AW'(dd2[2]);
      b3 <= AW'(md2[0]) + AW'(md2[1]) + AW'(md2[2]);
      c3 <= CW'(mm2[0]) + CW'(mm2[1]) + CW'(mm2[2]) - $signed(CW'(rr2));
      a4 <= a3;
      b4 <= b3;
      bhh4 <= bh3 * bh3;
      bhl4 <= bh3 * $signed({1'b0, bl3});
      bll4 <= bl3 * bl3;
      ahch4 <= ah3 * ch3;
      ahcl4 <= ah3 * $signed({1'b0, cl3});
      alch4 <= $signed({1'b0, al3}) * ch3;
      alcl4 <= al3 * cl3;
      degen4 <= (a3 == '0);
      dhit4 <= c3[CW-1] || (c3 == '0);
      early4 <= !c3[CW-1] && (c3 != '0) && !b3[AW-1] && (b3 != '0);
      disc5 <= XW'($signed({bhh4, bll4})) + (XW'(bhl4) <<< (W + 2))
             - XW'($signed({ahch4, alcl4})) - (XW'(ahcl4) <<< (W + 1))
             - (XW'(alch4) <<< (W + 1));
      side5.a <= a4;
      side5.b <= b4;
      side5.p0 <= p4[0];
      side5.p1 <= p4[1];
      side5.p2 <= p4[2];
      side5.d0 <= d4[0];
      side5.d1 <= d4[1];
      side5.d2 <= d4[2];
      side5.degen <= degen4;
      side5.dhit <= dhit4;
      side5.ok <= !degen4 && !early4;
    end
  end

  logic              sq_valid;
  logic [SW-1:0]     sq_root;
  ssi_pkg::sq_side_t sq_side;
  ssi_pkg::sq_side_t sq_in_side;

  always_comb begin
    sq_in_side = side5;
    sq_in_side.ok = side5.ok && !disc5[XW-1];
  end

  ssi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v5),
    .x        (disc5),
    .side_in  (sq_in_side),
    .out_valid(sq_valid),
    .root     (sq_root),
    .side_out (sq_side)
  );

  logic signed [NW-1:0] n_c;
  logic signed [DW-1:0] dsel [3];
  logic signed [W-1:0]  psel [3];

  always_comb begin
    n_c = -NW'(sq_side.b) - $signed(NW'(sq_root));
    dsel[0] = sq_side.d0;
    dsel[1] = sq_side.d1;
    dsel[2] = sq_side.d2;
    psel[0] = sq_side.p0;
    psel[1] = sq_side.p1;
    psel[2] = sq_side.p2;
  end

  logic [AW-1:0]       n6, a6;
  logic [DW-1:0]       mag6 [3];
  logic                neg6 [3];
  logic signed [W-1:0] p6 [3];
  logic                hit6, pos6;

  logic [2*W+1:0]      th7 [3];
  logic [2*W+1:0]      tl7 [3];
  logic [AW-1:0]       a7;
  logic                neg7 [3];
  logic signed [W-1:0] p7 [3];
  logic                hit7, pos7;

  logic [NUMW-1:0]    num8 [3];
  logic [DENW-1:0]    den8;
  ssi_pkg::div_side_t dside8 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (adv) begin
      v6 <= sq_valid;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n6 <= n_c[AW-1:0];
      a6 <= sq_side.a;
      hit6 <= sq_side.degen ? sq_side.dhit : (sq_side.ok && (n_c <= NW'(sq_side.a)));
      pos6 <= !sq_side.degen && !n_c[NW-1] && (n_c != '0);
      for (int i = 0; i < 3; i++) begin
        neg6[i] <= dsel[i][DW-1];
        mag6[i] <= dsel[i][DW-1] ? DW'(-dsel[i]) : DW'(dsel[i]);
        p6[i] <= psel[i];
        th7[i] <= n6[2*W+1:W+1] * mag6[i];
        tl7[i] <= n6[W:0] * mag6[i];
        neg7[i] <= neg6[i];
        p7[i] <= p6[i];
        num8[i] <= (NUMW'(th7[i]) << (W + 2)) + NUMW'({tl7[i], 1'b0}) + NUMW'(a7);
        dside8[i].p <= p7[i];
        dside8[i].neg <= neg7[i];
        dside8[i].hit <= hit7;
        dside8[i].pos <= pos7;
      end
      a7 <= a6;
      hit7 <= hit6;
      pos7 <= pos6;
      den8 <= {a7, 1'b0};
    end
  end

  logic               dv [3];
  logic [QW-1:0]      dq [3];
  ssi_pkg::div_side_t dso [3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    ssi_div u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (v8),
      .num      (num8[g]),
      .den      (den8),
      .side_in  (dside8[g]),
      .out_valid(dv[g]),
      .quo      (dq[g]),
      .side_out (dso[g])
    );
  end

  logic signed [W-1:0] pt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dso[i].hit) begin
        pt[i] = '0;
      end else if (!dso[i].pos) begin
        pt[i] = dso[i].p;
      end else if (dso[i].neg) begin
        pt[i] = dso[i].p - $signed(dq[i][W-1:0]);
      end else begin
        pt[i] = dso[i].p + $signed(dq[i][W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= dv[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.hit <= dso[0].hit;
      out_data.point_x <= pt[0];
      out_data.point_y <= pt[1];
      out_data.point_z <= pt[2];
    end
  end

  assign out_valid = v9;

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (dv[0] == dv[1]) && (dv[0] == dv[2]))
    else $error("divide lanes out of step");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |->
      (out_data.point_x == '0) && (out_data.point_y == '0) && (out_data.point_z == '0))
    else $error("point not zero on a miss");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(v8) && $stable(v5))
    else $error("pipeline moved during a stall");
`endif

endmodule
